// ----- hdl/sitda_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants and controller/datapath command and status types for the
// signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam int VALUE_W    = 32;
	localparam int CHAR_W     = 8;
	localparam int DIGIT_W    = 4;
	localparam int MAX_DIGITS = 10;
	localparam int IDX_W      = $clog2(MAX_DIGITS);

	localparam logic [VALUE_W-1:0] DIGIT_BASE = 32'd10;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;

	// floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
	localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int                 RECIP_SHIFT = 35;

	typedef struct packed {
		logic load;        // capture a new value, take its magnitude
		logic div_step;    // peel off one decimal digit
		logic emit_sign;   // load '-' into the output register
		logic emit_digit;  // load the current digit into the output register
	} sitda_cmd_t;

	typedef struct packed {
		logic neg;         // captured value was negative
		logic mag_small;   // remaining magnitude is a single digit
		logic idx_zero;    // digit pointer at the least significant digit
	} sitda_status_t;

endpackage
`default_nettype wire

// ----- hdl/sitda_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_in_if
// Valid/ready channel carrying one signed 32-bit value per transaction.
// ----------------------------------------------------------------------------
interface sitda_in_if;
	import sitda_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [VALUE_W-1:0]  value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);

endinterface
`default_nettype wire

// ----- hdl/sitda_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_out_if
// Valid/ready channel carrying one ASCII character and an end-of-text flag.
// ----------------------------------------------------------------------------
interface sitda_out_if;
	import sitda_pkg::*;

	logic               valid;
	logic               ready;
	logic [CHAR_W-1:0]  character;
	logic               last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);

endinterface
`default_nettype wire

// ----- hdl/sitda_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_datapath
// Magnitude register, divide-by-ten step, digit buffer and output register.
// ----------------------------------------------------------------------------
module sitda_datapath
	import sitda_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sitda_cmd_t          cmd,
	output sitda_status_t            status,
	input  wire logic [VALUE_W-1:0]  value,
	output logic [CHAR_W-1:0]        character,
	output logic                     last
);

	logic [VALUE_W-1:0]    mag_q;
	logic                  neg_q;
	logic [IDX_W-1:0]      idx_q;
	logic [DIGIT_W-1:0]    dig_q [MAX_DIGITS];
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;

	logic [2*VALUE_W-1:0]  prod;
	logic [VALUE_W-1:0]    quot;
	logic [DIGIT_W-1:0]    quot10_lo;
	logic [DIGIT_W-1:0]    rem;
	logic [VALUE_W-1:0]    abs_value;

	// reciprocal multiply; remainder only needs the low nibble
	assign prod      = {{VALUE_W{1'b0}}, mag_q} * {{VALUE_W{1'b0}}, RECIP_TEN};
	assign quot      = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
	assign quot10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
	assign rem       = mag_q[DIGIT_W-1:0] - quot10_lo;

	assign abs_value = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q <= 1'b0;
			idx_q <= '0;
		end else if (cmd.load) begin
			neg_q <= value[VALUE_W-1];
			idx_q <= '0;
		end else if (cmd.div_step) begin
			if (!status.mag_small)
				idx_q <= idx_q + IDX_W'(1);
		end else if (cmd.emit_digit) begin
			idx_q <= idx_q - IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			mag_q <= abs_value;
		else if (cmd.div_step)
			mag_q <= quot;
		if (cmd.div_step)
			dig_q[idx_q] <= rem;
		if (cmd.emit_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= CHAR_ZERO + CHAR_W'(dig_q[idx_q]);
			last_q <= status.idx_zero;
		end
	end

	assign status.neg       = neg_q;
	assign status.mag_small = (mag_q < DIGIT_BASE);
	assign status.idx_zero  = (idx_q == '0);

	assign character = char_q;
	assign last      = last_q;

endmodule
`default_nettype wire

// ----- hdl/sitda_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_ctrl
// Sequencer: accept, divide out digits, stream '-' if negative, then digits.
// ----------------------------------------------------------------------------
module sitda_ctrl
	import sitda_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output sitda_cmd_t          cmd,
	input  wire sitda_status_t  status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_SIGN,
		S_DIGIT
	} state_t;

	state_t  state_q;
	logic    out_valid_q;
	logic    out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == S_IDLE) && in_valid;
		cmd.div_step   = (state_q == S_DIV);
		cmd.emit_sign  = (state_q == S_SIGN) && out_free;
		cmd.emit_digit = (state_q == S_DIGIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit_sign || cmd.emit_digit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (status.mag_small)
						state_q <= status.neg ? S_SIGN : S_DIGIT;
				end
				S_SIGN: begin
					if (out_free)
						state_q <= S_DIGIT;
				end
				S_DIGIT: begin
					if (out_free && status.idx_zero)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ----- hdl/signed_int_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Operation: accept, divide out the 1 to 10 decimal digits, then emit '-'
//   for a negative number and the digits, most significant first.
// Throughput: one number at a time (shared divide-by-ten unit, single output
//   register); one character per cycle while the sink holds ready high.
// Reset: arst_n clears the sequencer, output valid, sign flag and digit
//   pointer; the magnitude, digit and character registers are not reset.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ASCII text, one character
// per output transaction, most significant first, with an end-of-text flag.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
	import sitda_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	sitda_in_if.sink    num,
	sitda_out_if.source text
);

	// Controller steps through idle -> divide -> (sign) -> digits. The
	// datapath holds the magnitude, peels one digit per divide step into
	// a small buffer (least significant first), then reads it back in
	// reverse. The output register decouples the sink: a new number is
	// accepted while the final character still waits to be taken.

	sitda_cmd_t     cmd;
	sitda_status_t  status;

	sitda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (num.valid),
		.in_ready  (num.ready),
		.out_valid (text.valid),
		.out_ready (text.ready),
		.cmd       (cmd),
		.status    (status)
	);

	sitda_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.value     (VALUE_W'(num.value)),
		.character (text.character),
		.last      (text.last)
	);

endmodule
`default_nettype wire

// ----- sim/signed_int_to_decimal_ascii_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Sends signed 32-bit numbers to the converter and checks every character of
// the decimal text that comes back against a predictor of its own, under
// random gaps and stalls, back-to-back traffic and a long output hold-off.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;
	import sitda_pkg::*;

	// One character of expected text, as the output channel carries it.
	typedef struct {
		logic [CHAR_W-1:0] character;
		logic              last;
	} text_char_t;

	logic clk;
	logic arst_n;

	sitda_in_if  num_if ();
	sitda_out_if text_if ();

	signed_int_to_decimal_ascii dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_if),
		.text   (text_if)
	);

	// Characters still owed by the block, oldest first.
	text_char_t expected_text[$];

	int error_count    = 0;
	int numbers_sent   = 0;
	int negatives_sent = 0;
	int chars_checked  = 0;

	// Idling switches for each side; a nonzero hold_request makes the
	// receiver keep ready low once for that many cycles before its next
	// transaction.
	bit source_idle  = 1'b1;
	bit sink_idle    = 1'b1;
	int hold_request = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hang guard: the slowest legal run (max gaps, 11 characters each waiting
	// out a full stall, plus the hold-off) is well under a tenth of this.
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Decimal text of a 32-bit two's-complement number: optional '-', then
	// the digits of the magnitude, most significant first, last flag on the
	// final digit. The magnitude is taken modulo 2**32, so the most negative
	// number comes out as 2147483648.
	function automatic void predict_text(input logic [VALUE_W-1:0] raw);
		logic                 neg;
		logic [VALUE_W-1:0]   mag;
		logic [DIGIT_W-1:0]   digits[MAX_DIGITS];
		int                   n;
		text_char_t           c;
		neg = raw[VALUE_W-1];
		mag = neg ? -raw : raw;
		n   = 0;
		do begin
			digits[n] = DIGIT_W'(mag % DIGIT_BASE);
			n++;
			mag = mag / DIGIT_BASE;
		end while (mag != 0 && n < MAX_DIGITS);
		if (neg) begin
			c.character = CHAR_MINUS;
			c.last      = 1'b0;
			expected_text.push_back(c);
		end
		for (int k = n - 1; k >= 0; k--) begin
			c.character = CHAR_ZERO + CHAR_W'(digits[k]);
			c.last      = (k == 0);
			expected_text.push_back(c);
		end
	endfunction

	// Random number with a random digit count, so short texts are as common
	// as long ones; a quarter are raw 32-bit patterns for full bit coverage.
	function automatic logic [VALUE_W-1:0] random_value();
		longint lo;
		longint hi;
		longint limit;
		longint mag;
		int     d;
		bit     neg;
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		d     = $urandom_range(1, MAX_DIGITS);
		neg   = $urandom_range(0, 1);
		limit = neg ? 64'd2147483648 : 64'd2147483647;
		lo    = (d == 1) ? 0 : longint'(10) ** (d - 1);
		hi    = longint'(10) ** d - 1;
		if (hi > limit)
			hi = limit;
		mag = lo + longint'($urandom_range(0, 32'(hi - lo)));
		return neg ? -mag[VALUE_W-1:0] : mag[VALUE_W-1:0];
	endfunction

	// Offers one number, optionally after a random gap, and records its text
	// once the input transaction completes. Valid stays high on return so a
	// following number with no gap is offered in the very next cycle.
	task automatic send_number(input logic [VALUE_W-1:0] v);
		int gap;
		gap = source_idle ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			num_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		num_if.valid <= 1'b1;
		num_if.value <= v;
		do @(posedge clk); while (!num_if.ready);
		predict_text(v);
		numbers_sent++;
		if (v[VALUE_W-1])
			negatives_sent++;
	endtask

	// Receiver and checker: stalls per transaction as configured, then
	// compares each character with the oldest expectation.
	initial begin : text_sink
		int         stall;
		bit         hold_done;
		text_char_t exp_c;
		hold_done     = 1'b0;
		text_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request > 0 && !hold_done) begin
				stall     = hold_request;
				hold_done = 1'b1;
			end else begin
				stall = sink_idle ? $urandom_range(0, 14) : 0;
			end
			if (stall > 0) begin
				text_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			text_if.ready <= 1'b1;
			do @(posedge clk); while (!text_if.valid);
			chars_checked++;
			if (expected_text.size() == 0) begin
				$error("unexpected character 0x%02h last=%0b",
					text_if.character, text_if.last);
				error_count++;
			end else begin
				exp_c = expected_text.pop_front();
				if (text_if.character !== exp_c.character) begin
					$error("character: expected 0x%02h, got 0x%02h",
						exp_c.character, text_if.character);
					error_count++;
				end
				if (text_if.last !== exp_c.last) begin
					$error("last: expected %0b, got %0b", exp_c.last, text_if.last);
					error_count++;
				end
			end
		end
	end

	// Extremes, digit counts one to three and five to ten, both signs, zero and the most negative
	// number, plus alternating bit patterns.
	task automatic test_directed();
		logic [VALUE_W-1:0] values[] = '{
			32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
			32'sd99, -32'sd100, 32'sd12345, -32'sd678901, 32'sd9999999,
			-32'sd10000000, 32'sd999999999, -32'sd999999999, 32'sd1000000000,
			32'sd1234567890, 32'sd2147483647, -32'sd2147483647,
			32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
		};
		source_idle = 1'b1;
		sink_idle   = 1'b1;
		foreach (values[i])
			send_number(values[i]);
	endtask

	task automatic test_random_idle(input int count);
		source_idle = 1'b1;
		sink_idle   = 1'b1;
		repeat (count) send_number(random_value());
	endtask

	// No idling on either side: full-rate streaming.
	task automatic test_back_to_back(input int count);
		source_idle = 1'b0;
		sink_idle   = 1'b0;
		repeat (count) send_number(random_value());
	endtask

	// Receiver holds ready low for a long stretch while the sender keeps
	// offering numbers, so the block fills and stalls its input.
	task automatic test_output_hold(input int count);
		source_idle  = 1'b0;
		sink_idle    = 1'b0;
		hold_request = 200;
		repeat (count) send_number(random_value());
	endtask

	// Each side idling alone, to shift where gaps fall.
	task automatic test_one_side_idle(input int count);
		source_idle = 1'b1;
		sink_idle   = 1'b0;
		repeat (count / 2) send_number(random_value());
		source_idle = 1'b0;
		sink_idle   = 1'b1;
		repeat (count - count / 2) send_number(random_value());
	endtask

	initial begin
		arst_n         <= 1'b0;
		num_if.valid   <= 1'b0;
		num_if.value   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_idle(120);
		test_back_to_back(60);
		test_output_hold(30);
		test_one_side_idle(40);

		num_if.valid <= 1'b0;
		while (expected_text.size() != 0)
			@(posedge clk);
		// Give stray extra characters time to show up.
		repeat (40) @(posedge clk);

		$display("Converted %0d numbers (%0d negative), checked %0d characters",
			numbers_sent, negatives_sent, chars_checked);
		$display("Covered extremes, all digit counts, idling, streaming and hold-off");
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
